@@ rtl/core/afr_pkg.sv @@
// ---------------------------------------------------------------------------
// afr_pkg: shared types and constants for the absorbance core
// word layouts, status codes, register indexes and the log2 squaring step
// ---------------------------------------------------------------------------
package afr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int LG_FRAC     = 28;
    localparam int TRANS_W     = FRAC_BITS + 1;
    localparam int ABS_W       = FRAC_BITS + 4;
    localparam int ABS_SHIFT   = LG_FRAC + 32 - FRAC_BITS;
    localparam int LG_W        = LG_FRAC + 5;
    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CAL_ZERO = 2'd1,
        ST_SMP_ZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_CAL_RED   = 2'd0,
        REG_CAL_GREEN = 2'd1,
        REG_CAL_BLUE  = 2'd2,
        REG_CAL_WHITE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [31:0] sample_freq;
    } in_t;

    typedef struct packed {
        logic [1:0]         channel_out;
        logic [TRANS_W-1:0] transmission;
        logic [ABS_W-1:0]   absorbance;
        status_t            status;
        logic               cal_all_valid;
    } out_t;

    // side info carried down the pipe next to the arithmetic
    typedef struct packed {
        logic [1:0] channel;
        status_t    status;
        logic       bypass;
        logic       cal_ok;
    } side_t;

    typedef struct packed {
        logic [31:0] m;
        logic        fbit;
    } sq_res_t;

    // one fraction bit of log2: square the Q1.31 mantissa and renormalize
    function automatic sq_res_t lg_step(input logic [31:0] m);
        logic [63:0] p;
        sq_res_t     r;
        p = {32'd0, m} * {32'd0, m};
        if (p[63])
        begin
            r.m    = p[63:32];
            r.fbit = 1'b1;
        end
        else
        begin
            r.m    = p[62:31];
            r.fbit = 1'b0;
        end
        return r;
    endfunction

    // index of the top set bit, zero for zero
    function automatic logic [4:0] lead_one(input logic [31:0] x);
        logic [4:0] e;
        e = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
                e = 5'(i);
        end
        return e;
    endfunction

endpackage

@@ rtl/core/absorbance_from_frequency_ratio_core.sv @@
// ---------------------------------------------------------------------------
// absorbance_from_frequency_ratio_core: transmission and base-10 absorbance
// per-channel calibration, pipelined restoring divider and log2 by squaring
// ---------------------------------------------------------------------------
//  port group | handshake            | word
//  -----------+----------------------+---------------------------------------
//  in         | in_valid / in_ready  | in_data  (channel, sample_freq)
//  out        | out_valid / out_ready| out_data (channel_out .. cal_all_valid)
//  cfg        | cfg_we               | cfg_index, cfg_wdata (four cal registers)
//
//  one word per cycle unless out stalls; the pipe depth is set by the 28
//  squaring stages of the log2 units (the divider runs alongside them)
//  rst_n clears valid bits and sets all calibrations to 1
//  a stall on out freezes the whole pipe; in_ready is low only then
// ---------------------------------------------------------------------------
module absorbance_from_frequency_ratio_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  afr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output afr_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);
    import afr_pkg::*;

    localparam int ITER = LG_FRAC;

    logic [31:0] cal_reg [4];
    logic        adv;
    logic        cal_ok;

    // entry stage
    logic        v0_reg;
    side_t       sd0_reg;
    logic [31:0] smp0_reg, cal0_reg;
    side_t       sd0_next;
    logic [31:0] cal_sel;

    // leading one stage
    logic        v1_reg;
    side_t       sd1_reg;
    logic [31:0] smp1_reg, cal1_reg;
    logic [4:0]  ec1_reg, es1_reg;

    // iteration stages, index 0 is the normalized entry
    logic              vi_reg  [0:ITER];
    side_t             sdi_reg [0:ITER];
    logic [31:0]       mc_reg  [0:ITER];
    logic [31:0]       ms_reg  [0:ITER];
    logic [LG_W-1:0]   rc_reg  [0:ITER];
    logic [LG_W-1:0]   rs_reg  [0:ITER];
    logic [31:0]       rem_reg [0:ITER];
    logic [31:0]       cd_reg  [0:ITER];
    logic [FRAC_BITS-1:0] q_reg [0:ITER];
    sq_res_t           stc [1:ITER];
    sq_res_t           sts [1:ITER];

    // difference, product and output stages
    logic            vd_reg, vm_reg, out_valid_reg;
    side_t           sdd_reg, sdm_reg;
    logic [FRAC_BITS-1:0] qd_reg, qm_reg;
    logic [LG_W-1:0] d_reg;
    logic [63:0]     p_reg;
    out_t            out_reg;

    logic [64:0]     rnd_sum;
    logic [64:0]     rnd_sh;
    out_t            out_next;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign cal_ok   = (cal_reg[0] != 32'd0) && (cal_reg[1] != 32'd0)
                   && (cal_reg[2] != 32'd0) && (cal_reg[3] != 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                cal_reg[i] <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CAL_RED:   cal_reg[0] <= cfg_wdata;
                REG_CAL_GREEN: cal_reg[1] <= cfg_wdata;
                REG_CAL_BLUE:  cal_reg[2] <= cfg_wdata;
                REG_CAL_WHITE: cal_reg[3] <= cfg_wdata;
                default:       cal_reg[0] <= cal_reg[0];
            endcase
        end
    end

    always_comb
    begin
        cal_sel          = cal_reg[in_data.channel];
        sd0_next.channel = in_data.channel;
        sd0_next.cal_ok  = cal_ok;
        if (cal_sel == 32'd0)
            sd0_next.status = ST_CAL_ZERO;
        else if (in_data.sample_freq == 32'd0)
            sd0_next.status = ST_SMP_ZERO;
        else
            sd0_next.status = ST_OK;
        sd0_next.bypass = (sd0_next.status != ST_OK)
                       || (in_data.sample_freq >= cal_sel);
    end

    always_comb
    begin
        for (int k = 1; k <= ITER; k++)
        begin
            stc[k] = lg_step(mc_reg[k-1]);
            sts[k] = lg_step(ms_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= ITER; k++)
                vi_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            vi_reg[0]     <= v1_reg;
            for (int k = 1; k <= ITER; k++)
                vi_reg[k] <= vi_reg[k-1];
            vd_reg        <= vi_reg[ITER];
            vm_reg        <= vd_reg;
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd0_reg  <= sd0_next;
            smp0_reg <= in_data.sample_freq;
            cal0_reg <= cal_sel;

            sd1_reg  <= sd0_reg;
            smp1_reg <= smp0_reg;
            cal1_reg <= cal0_reg;
            ec1_reg  <= lead_one(cal0_reg);
            es1_reg  <= lead_one(smp0_reg);

            sdi_reg[0] <= sd1_reg;
            mc_reg[0]  <= cal1_reg << (5'd31 - ec1_reg);
            ms_reg[0]  <= smp1_reg << (5'd31 - es1_reg);
            rc_reg[0]  <= LG_W'(ec1_reg);
            rs_reg[0]  <= LG_W'(es1_reg);
            rem_reg[0] <= smp1_reg;
            cd_reg[0]  <= cal1_reg;
            q_reg[0]   <= '0;

            for (int k = 1; k <= ITER; k++)
            begin
                sdi_reg[k] <= sdi_reg[k-1];
                mc_reg[k]  <= stc[k].m;
                ms_reg[k]  <= sts[k].m;
                rc_reg[k]  <= {rc_reg[k-1][LG_W-2:0], stc[k].fbit};
                rs_reg[k]  <= {rs_reg[k-1][LG_W-2:0], sts[k].fbit};
                cd_reg[k]  <= cd_reg[k-1];
                if (k <= FRAC_BITS)
                begin
                    // restoring step: remainder stays below the divisor
                    if ({rem_reg[k-1], 1'b0} >= {1'b0, cd_reg[k-1]})
                    begin
                        rem_reg[k] <= 32'({rem_reg[k-1], 1'b0} - {1'b0, cd_reg[k-1]});
                        q_reg[k]   <= {q_reg[k-1][FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k] <= {rem_reg[k-1][30:0], 1'b0};
                        q_reg[k]   <= {q_reg[k-1][FRAC_BITS-2:0], 1'b0};
                    end
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                end
            end

            sdd_reg <= sdi_reg[ITER];
            qd_reg  <= q_reg[ITER];
            d_reg   <= rc_reg[ITER] - rs_reg[ITER];

            sdm_reg <= sdd_reg;
            qm_reg  <= qd_reg;
            p_reg   <= 64'({31'd0, d_reg} * {33'd0, LOG10_2_Q32});

            out_reg <= out_next;
        end
    end

    always_comb
    begin
        rnd_sum = {1'b0, p_reg} + (65'd1 << (ABS_SHIFT - 1));
        rnd_sh  = rnd_sum >> ABS_SHIFT;
        out_next.channel_out   = sdm_reg.channel;
        out_next.status        = sdm_reg.status;
        out_next.cal_all_valid = sdm_reg.cal_ok;
        if (sdm_reg.bypass)
        begin
            out_next.absorbance   = '0;
            out_next.transmission = (sdm_reg.status == ST_OK)
                                  ? TRANS_W'(1 << FRAC_BITS) : '0;
        end
        else
        begin
            out_next.transmission = {1'b0, qm_reg};
            if (rnd_sh > 65'((1 << ABS_W) - 1))
                out_next.absorbance = '1;
            else
                out_next.absorbance = rnd_sh[ABS_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK
        |-> out_data.transmission == '0 && out_data.absorbance == '0)
        else $error("error status with nonzero result");

    a_trans_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.transmission <= TRANS_W'(1 << FRAC_BITS))
        else $error("transmission above one");

    a_full_trans: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK
        && out_data.transmission == TRANS_W'(1 << FRAC_BITS)
        |-> out_data.absorbance == '0)
        else $error("absorbance at full transmission");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vm_reg && out_valid && !out_ready |=> vm_reg && out_valid)
        else $error("pipe lost a word during stall");

endmodule

@@ verif/afr_checker.sv @@
// ---------------------------------------------------------------------------
// afr_checker: absorbance scoreboard
// watches the in, out and cfg ports, predicts each result word from the
// calibration registers and compares it field by field with the block output
// ---------------------------------------------------------------------------
module afr_checker
    import afr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_t         in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] cal_regs [4];
    out_t        expected_words [$];

    assign pending = expected_words.size();

    // log2 in Q5.28 by repeated squaring
    function automatic logic [63:0] log2_q28(input logic [31:0] x);
        logic [63:0]  m;
        logic [63:0]  r;
        logic [127:0] sq;
        int           e;
        e = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
                e = i;
        end
        m = 64'(x) << (31 - e);
        r = 64'(e);
        for (int i = 0; i < LG_FRAC; i++)
        begin
            sq = 128'(m) * 128'(m);
            m = 64'(sq >> 31);
            r = r << 1;
            if (m >= 64'h1_0000_0000)
            begin
                r = r | 64'd1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic out_t predict_absorbance(input in_t w);
        out_t         o;
        logic [31:0]  cal;
        logic [63:0]  d;
        logic [127:0] p;
        logic [127:0] a;
        cal = cal_regs[w.channel];
        o.channel_out = w.channel;
        o.transmission = '0;
        o.absorbance = '0;
        o.cal_all_valid = (cal_regs[0] != 0) && (cal_regs[1] != 0)
                          && (cal_regs[2] != 0) && (cal_regs[3] != 0);
        if (cal == 0)
            o.status = ST_CAL_ZERO;
        else if (w.sample_freq == 0)
            o.status = ST_SMP_ZERO;
        else
        begin
            o.status = ST_OK;
            if (w.sample_freq >= cal)
                o.transmission = TRANS_W'(1 << FRAC_BITS);
            else
            begin
                o.transmission = TRANS_W'((64'(w.sample_freq) << FRAC_BITS) / 64'(cal));
                d = log2_q28(cal) - log2_q28(w.sample_freq);
                p = 128'(d) * 128'(LOG10_2_Q32);
                a = (p + (128'd1 << (ABS_SHIFT - 1))) >> ABS_SHIFT;
                if (a > 128'((1 << ABS_W) - 1))
                    a = 128'((1 << ABS_W) - 1);
                o.absorbance = ABS_W'(a);
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                cal_regs[i] <= 32'd1;
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            // a word taken this edge sees the registers as they were before it
            if (in_valid && in_ready)
                expected_words.push_back(predict_absorbance(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    e = expected_words.pop_front();
                    if (out_data.channel_out !== e.channel_out)
                        report_mismatch("channel_out", out_data.channel_out, e.channel_out);
                    if (out_data.transmission !== e.transmission)
                        report_mismatch("transmission", out_data.transmission,
                                        e.transmission);
                    if (out_data.absorbance !== e.absorbance)
                        report_mismatch("absorbance", out_data.absorbance, e.absorbance);
                    if (out_data.status !== e.status)
                        report_mismatch("status", out_data.status, e.status);
                    if (out_data.cal_all_valid !== e.cal_all_valid)
                        report_mismatch("cal_all_valid", out_data.cal_all_valid,
                                        e.cal_all_valid);
                end
            end
            if (cfg_we)
                cal_regs[cfg_index] <= cfg_wdata;
        end
    end

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: absorbance core stimulus and verdict
// drives directed and random words across several calibration settings with
// bursty input and a stalling receiver; the checker judges every result
// ---------------------------------------------------------------------------
module testbench;
    import afr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = LG_FRAC + 6;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          hold_off;
    bit          hold_req;
    bit          hold_seen;
    bit          stall_random;

    absorbance_from_frequency_ratio_core u_dut (.*);

    afr_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall pattern or always ready, one long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off  <= 0;
            hold_seen <= 1'b0;
        end
        else
        begin
            hold_seen <= hold_req;
            if (hold_req && !hold_seen)
            begin
                hold_off  <= HOLD_LEN - 1;
                out_ready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off  <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else if (stall_random)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout");
            $display("FAIL absorbance_from_frequency_ratio_core");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] ch, input logic [31:0] smp);
        in_valid <= 1'b1;
        in_data <= '{channel: ch, sample_freq: smp};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_cal(input reg_idx_t idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_freq();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(1, 2000);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                send_word(2'($urandom_range(0, 3)), rand_freq());
                burst--;
                left--;
            end
            gap($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        hold_req = 1'b0;
        stall_random = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibrations are all 1
        send_word(2'd0, 32'd0);
        send_word(2'd1, 32'd1);
        send_word(2'd2, 32'hFFFF_FFFF);
        drain();

        write_cal(REG_CAL_RED, 32'hFFFF_FFFF);
        write_cal(REG_CAL_GREEN, 32'd1000);
        write_cal(REG_CAL_BLUE, 32'd0);
        write_cal(REG_CAL_WHITE, 32'h8000_0000);
        // deepest absorbance, tiny ratios, equal and above calibration
        send_word(2'd0, 32'd1);
        send_word(2'd0, 32'd2);
        send_word(2'd0, 32'hFFFF_FFFE);
        send_word(2'd0, 32'hFFFF_FFFF);
        send_word(2'd1, 32'd999);
        send_word(2'd1, 32'd1000);
        send_word(2'd1, 32'd1001);
        send_word(2'd1, 32'd0);
        send_word(2'd1, 32'd500);
        send_word(2'd2, 32'd0);
        send_word(2'd2, 32'd77);
        send_word(2'd3, 32'h4000_0000);
        send_word(2'd3, 32'h7FFF_FFFF);
        send_word(2'd3, 32'd1);
        send_word(2'd3, 32'h5555_5555);
        drain();

        // random with some calibration zero
        stall_random = 1'b1;
        random_phase(200);
        drain();

        write_cal(REG_CAL_BLUE, 32'd3_000_000);
        write_cal(REG_CAL_RED, $urandom);
        write_cal(REG_CAL_GREEN, 32'hAAAA_AAAA);
        write_cal(REG_CAL_WHITE, 32'd1);
        random_phase(250);
        drain();

        // long receiver hold-off while words keep coming
        hold_req <= 1'b1;
        random_phase(120);
        drain();

        write_cal(REG_CAL_WHITE, 32'h5555_5555);
        write_cal(REG_CAL_RED, 32'd12345);
        stall_random = 1'b0;
        random_phase(100);
        stall_random = 1'b1;
        random_phase(200);
        drain();

        if (fail_count == 0)
            $display("PASS absorbance_from_frequency_ratio_core");
        else
            $display("FAIL absorbance_from_frequency_ratio_core");
        $finish;
    end

endmodule
